### rtl/core/vector_add_sub_memory_engine_top_macros.svh
// Assertion macros shared by the vector engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef VECTOR_ADD_SUB_MEMORY_ENGINE_TOP_MACROS_SVH
`define VECTOR_ADD_SUB_MEMORY_ENGINE_TOP_MACROS_SVH

// Same-cycle implication under active-low reset.
`define VASME_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under active-low reset.
`define VASME_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/vasme_pkg.sv
// Shared constants for the vector add/subtract memory engine.
// No dependencies; used by the ALU and the top level.
`default_nettype none
package vasme_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned BASE_W = 12;
  localparam int unsigned LEN_W  = 13;

  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUB   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

endpackage
`default_nettype wire

### rtl/core/vasme_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module vasme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/core/vasme_alu.sv
// Shared 32-bit add/subtract unit, wraps modulo 2^32.
// Depends on vasme_pkg.
`default_nettype none
module vasme_alu (
  input  wire logic                          op_sub,
  input  wire logic [vasme_pkg::WORD_W-1:0]  a,
  input  wire logic [vasme_pkg::WORD_W-1:0]  b,
  output logic      [vasme_pkg::WORD_W-1:0]  y
);

  logic [vasme_pkg::WORD_W-1:0] b_op;

  assign b_op = op_sub ? ~b : b;
  assign y    = a + b_op + {{(vasme_pkg::WORD_W-1){1'b0}}, op_sub};

endmodule
`default_nettype wire

### rtl/core/vector_add_sub_memory_engine_top.sv
// Vector add/subtract memory engine; uses vasme_pkg, vasme_ram, vasme_alu and the macros.
// Each transfer first reduces its addresses: any at or above MEM_WORDS loses the depth
// by repeated subtraction (never needed at the default depth). An add or subtract then reads
// the first operand, then the second, and writes the result for each element. One item at
// a time: the next input transfer can come in the cycle after the result is registered.
// Reset (rst_n low, synchronous) clears the sequencer and result valid; memory is kept.
`default_nettype none
`include "vector_add_sub_memory_engine_top_macros.svh"
module vector_add_sub_memory_engine_top #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [vasme_pkg::KIND_W-1:0]         in_kind,
  input  wire logic [vasme_pkg::BASE_W-1:0]         in_word_address,
  input  wire logic signed [vasme_pkg::WORD_W-1:0]  in_write_value,
  input  wire logic [vasme_pkg::BASE_W-1:0]         in_dest_base,
  input  wire logic [vasme_pkg::BASE_W-1:0]         in_first_base,
  input  wire logic [vasme_pkg::BASE_W-1:0]         in_second_base,
  input  wire logic [vasme_pkg::LEN_W-1:0]          in_vector_length,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [vasme_pkg::WORD_W-1:0]       out_read_value,
  output logic                                      out_status
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned PW = (AW > vasme_pkg::BASE_W) ? AW : vasme_pkg::BASE_W;
  localparam logic [PW:0] DEPTH_L = (PW+1)'(MEM_WORDS);

  typedef enum logic [3:0] {
    ST_IDLE, ST_REDUCE, ST_WRITE, ST_READ, ST_RD_WAIT,
    ST_RD_A, ST_RD_B, ST_EXEC, ST_DONE
  } state_t;

  state_t                            state_r;
  logic [vasme_pkg::KIND_W-1:0]      kind_r;
  logic [PW-1:0]                     addr_r, dst_r, s1_r, s2_r;
  logic [vasme_pkg::WORD_W-1:0]      wval_r, a_r, rval_r;
  logic [vasme_pkg::LEN_W-1:0]       cnt_r;
  logic                              status_r;
  logic                              out_valid_r;
  logic [vasme_pkg::WORD_W-1:0]      out_value_r;
  logic                              out_status_r;

  logic                              addr_big, dst_big, s1_big, s2_big;
  logic [PW-1:0]                     dst_inc, s1_inc, s2_inc;
  logic                              ram_we;
  logic [PW-1:0]                     ram_ptr;
  logic [vasme_pkg::WORD_W-1:0]      ram_wdata, ram_rdata, alu_y;
  logic                              accept;
  logic                              out_free;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(1);
    return (s == DEPTH_L) ? '0 : s[PW-1:0];
  endfunction

  assign addr_big = ({1'b0, addr_r} >= DEPTH_L);
  assign dst_big  = ({1'b0, dst_r}  >= DEPTH_L);
  assign s1_big   = ({1'b0, s1_r}   >= DEPTH_L);
  assign s2_big   = ({1'b0, s2_r}   >= DEPTH_L);
  assign dst_inc  = ptr_inc(dst_r);
  assign s1_inc   = ptr_inc(s1_r);
  assign s2_inc   = ptr_inc(s2_r);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (state_r)
      ST_RD_A: ram_ptr = s1_r;
      ST_RD_B: ram_ptr = s2_r;
      ST_EXEC: ram_ptr = dst_r;
      default: ram_ptr = addr_r;
    endcase
  end

  assign ram_we    = (state_r == ST_WRITE) || (state_r == ST_EXEC);
  assign ram_wdata = (state_r == ST_WRITE) ? wval_r : alu_y;

  vasme_ram #(
    .WIDTH (vasme_pkg::WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_ptr[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  vasme_alu u_alu (
    .op_sub (kind_r == vasme_pkg::KIND_SUB),
    .a      (a_r),
    .b      (ram_rdata),
    .y      (alu_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            kind_r   <= in_kind;
            addr_r   <= PW'(in_word_address);
            dst_r    <= PW'(in_dest_base);
            s1_r     <= PW'(in_first_base);
            s2_r     <= PW'(in_second_base);
            wval_r   <= in_write_value;
            cnt_r    <= in_vector_length;
            rval_r   <= '0;
            status_r <= vasme_pkg::STATUS_OK;
            state_r  <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (addr_big) addr_r <= addr_r - DEPTH_L[PW-1:0];
          if (dst_big)  dst_r  <= dst_r  - DEPTH_L[PW-1:0];
          if (s1_big)   s1_r   <= s1_r   - DEPTH_L[PW-1:0];
          if (s2_big)   s2_r   <= s2_r   - DEPTH_L[PW-1:0];
          if (!(addr_big || dst_big || s1_big || s2_big)) begin
            case (kind_r) inside
              vasme_pkg::KIND_WRITE: state_r <= ST_WRITE;
              vasme_pkg::KIND_READ:  state_r <= ST_READ;
              vasme_pkg::KIND_ADD, vasme_pkg::KIND_SUB: begin
                state_r <= (cnt_r == '0) ? ST_DONE : ST_RD_A;
              end
              vasme_pkg::KIND_STOP:  state_r <= ST_DONE;
              default: begin
                status_r <= vasme_pkg::STATUS_BAD;
                state_r  <= ST_DONE;
              end
            endcase
          end
        end
        ST_WRITE:   state_r <= ST_DONE;
        ST_READ:    state_r <= ST_RD_WAIT;
        ST_RD_WAIT: begin
          rval_r  <= ram_rdata;
          state_r <= ST_DONE;
        end
        ST_RD_A:    state_r <= ST_RD_B;
        ST_RD_B: begin
          a_r     <= ram_rdata;
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          dst_r   <= dst_inc;
          s1_r    <= s1_inc;
          s2_r    <= s2_inc;
          cnt_r   <= cnt_r - vasme_pkg::LEN_W'(1);
          state_r <= (cnt_r == vasme_pkg::LEN_W'(1)) ? ST_DONE : ST_RD_A;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= rval_r;
            out_status_r <= status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  `VASME_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != ST_IDLE, "accept left idle")
  `VASME_ASSERT_NOW(a_exec_count, clk, rst_n, state_r == ST_EXEC, cnt_r != '0, "zero count step")
  `VASME_ASSERT_NOW(a_we_state, clk, rst_n, ram_we, in_stall, "write while idle")
  `VASME_ASSERT_NOW(a_ptr_range, clk, rst_n, state_r == ST_EXEC, !(dst_big || s1_big), "bad pointer")

endmodule
`default_nettype wire
